/* sv/assert_macros.svh */
// assertion helpers for the file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, masked while arst_n is low
`define GBPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbps assertion failed");

// next-cycle implication, sampled on clk, masked while arst_n is low
`define GBPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbps assertion failed");

`endif

/* sv/gbps_pkg.sv */
package gbps_pkg;

	// data width of the number and of both primes
	localparam int WIDTH = 32;
	// bit counter width of the shift-subtract remainder unit
	localparam int CNT_W = $clog2(WIDTH);

	// result forms
	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_FOUR = 2'd1;
	localparam logic [1:0] RES_ODD  = 2'd2;
	localparam logic [1:0] RES_PAIR = 2'd3;

	// candidate sources
	localparam logic [1:0] CSEL_P   = 2'd0;
	localparam logic [1:0] CSEL_NP  = 2'd1;
	localparam logic [1:0] CSEL_NM2 = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic       load_n;
		logic       init_p;
		logic       step_p;
		logic       load_c;
		logic [1:0] c_sel;
		logic       test_init;
		logic       div_init;
		logic       div_step;
		logic       next_d;
		logic       res_load;
		logic [1:0] res_sel;
	} gbps_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic n_lt4;
		logic n_odd;
		logic n_is4;
		logic p_gt_np;
		logic sq_gt_c;
		logic rem_zero;
		logic div_last;
	} gbps_sts_t;

endpackage

/* sv/gbps_if.sv */
// input channel: one number per word
interface gbps_in_if import gbps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] even_value;

	modport source (output valid, output even_value, input ready);
	modport sink (input valid, input even_value, output ready);
endinterface

// output channel: one prime pair per word
interface gbps_out_if import gbps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] first_prime;
	logic [WIDTH-1:0] second_prime;
	logic             found;

	modport source (output valid, output first_prime, output second_prime, output found,
		input ready);
	modport sink (input valid, input first_prime, input second_prime, input found,
		output ready);
endinterface

/* sv/gbps_dp.sv */
module gbps_dp import gbps_pkg::*; (
	input  logic             clk,
	input  gbps_cmd_t        cmd,
	output gbps_sts_t        sts,
	input  logic [WIDTH-1:0] even_value,
	output logic [WIDTH-1:0] first_prime,
	output logic [WIDTH-1:0] second_prime,
	output logic             found
);

	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] p_q;
	logic [WIDTH-1:0] c_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH:0]   sq_q;
	logic [WIDTH-1:0] sh_q;
	logic [WIDTH-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] first_q;
	logic [WIDTH-1:0] second_q;
	logic             found_q;

	logic [WIDTH-1:0] np;
	logic [WIDTH-1:0] nm2;
	logic [WIDTH-1:0] c_next;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             trial_ge;

	// partner of the first prime and the odd-number partner
	assign np  = n_q - p_q;
	assign nm2 = n_q - WIDTH'(2);

	// one restoring step of candidate mod divisor
	assign trial    = {rem_q, sh_q[WIDTH-1]};
	assign diff     = trial - {1'b0, d_q};
	assign trial_ge = trial >= {1'b0, d_q};

	// candidate select
	always_comb begin
		case (cmd.c_sel)
			CSEL_P:   c_next = p_q;
			CSEL_NP:  c_next = np;
			CSEL_NM2: c_next = nm2;
			default:  c_next = p_q;
		endcase
	end

	// number, first prime and candidate
	always_ff @(posedge clk) begin
		if (cmd.load_n) n_q <= even_value;
		if (cmd.init_p) p_q <= WIDTH'(3);
		else if (cmd.step_p) p_q <= p_q + WIDTH'(2);
		if (cmd.load_c) c_q <= c_next;
	end

	// divisor and its square, the square kept up by adding 2d+1
	always_ff @(posedge clk) begin
		if (cmd.test_init) begin
			d_q  <= WIDTH'(2);
			sq_q <= (WIDTH+1)'(4);
		end else if (cmd.next_d) begin
			d_q  <= d_q + WIDTH'(1);
			sq_q <= sq_q + {d_q, 1'b1};
		end
	end

	// remainder unit, one bit of the candidate per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			sh_q  <= c_q;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			sh_q  <= {sh_q[WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_NONE: begin
					first_q  <= '0;
					second_q <= '0;
					found_q  <= 1'b0;
				end
				RES_FOUR: begin
					first_q  <= WIDTH'(2);
					second_q <= WIDTH'(2);
					found_q  <= 1'b1;
				end
				RES_ODD: begin
					first_q  <= WIDTH'(2);
					second_q <= nm2;
					found_q  <= 1'b1;
				end
				default: begin
					first_q  <= p_q;
					second_q <= np;
					found_q  <= 1'b1;
				end
			endcase
		end
	end

	// status back to the controller
	assign sts.n_lt4    = n_q < WIDTH'(4);
	assign sts.n_odd    = n_q[0];
	assign sts.n_is4    = n_q == WIDTH'(4);
	assign sts.p_gt_np  = p_q > np;
	assign sts.sq_gt_c  = sq_q > {1'b0, c_q};
	assign sts.rem_zero = rem_q == '0;
	assign sts.div_last = cnt_q == CNT_W'(WIDTH-1);

	assign first_prime  = first_q;
	assign second_prime = second_q;
	assign found        = found_q;

endmodule

/* sv/gbps_ctrl.sv */
module gbps_ctrl import gbps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  gbps_sts_t sts,
	output gbps_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLASS = 3'd1;
	localparam logic [2:0] S_LOADP = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_REM   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       second_q, second_d;
	logic       odd_q, odd_d;
	logic [1:0] res_q, res_d;
	logic       out_valid_q, out_valid_d;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// search sequencer
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		second_d = second_q;
		odd_d    = odd_q;
		res_d    = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_n = 1'b1;
					state_d    = S_CLASS;
				end
			end
			S_CLASS: begin
				if (sts.n_lt4) begin
					res_d   = RES_NONE;
					state_d = S_FIN;
				end else if (sts.n_odd) begin
					cmd.load_c    = 1'b1;
					cmd.c_sel     = CSEL_NM2;
					cmd.test_init = 1'b1;
					second_d      = 1'b1;
					odd_d         = 1'b1;
					state_d       = S_CHK;
				end else if (sts.n_is4) begin
					res_d   = RES_FOUR;
					state_d = S_FIN;
				end else begin
					cmd.init_p = 1'b1;
					odd_d      = 1'b0;
					state_d    = S_LOADP;
				end
			end
			S_LOADP: begin
				if (sts.p_gt_np) begin
					res_d   = RES_NONE;
					state_d = S_FIN;
				end else begin
					cmd.load_c    = 1'b1;
					cmd.c_sel     = CSEL_P;
					cmd.test_init = 1'b1;
					second_d      = 1'b0;
					state_d       = S_CHK;
				end
			end
			S_CHK: begin
				// divisor squared past the candidate: candidate is prime
				if (sts.sq_gt_c) begin
					if (!second_q) begin
						cmd.load_c    = 1'b1;
						cmd.c_sel     = CSEL_NP;
						cmd.test_init = 1'b1;
						second_d      = 1'b1;
					end else begin
						res_d   = odd_q ? RES_ODD : RES_PAIR;
						state_d = S_FIN;
					end
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_REM;
			end
			S_REM: begin
				if (sts.rem_zero) begin
					if (odd_q) begin
						res_d   = RES_NONE;
						state_d = S_FIN;
					end else begin
						cmd.step_p = 1'b1;
						state_d    = S_LOADP;
					end
				end else begin
					cmd.next_d = 1'b1;
					state_d    = S_CHK;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = res_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output word valid
	always_comb begin
		if (state_q == S_FIN && slot_free) out_valid_d = 1'b1;
		else if (out_ready) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			second_q    <= 1'b0;
			odd_q       <= 1'b0;
			res_q       <= RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			second_q    <= second_d;
			odd_q       <= odd_d;
			res_q       <= res_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

/* sv/goldbach_prime_pair_search.sv */
// channel | dir | words carry
// din     | in  | even_value
// dout    | out | first_prime, second_prime, found
//
// each divisor tried takes one square compare, WIDTH bit steps of the
// shift-subtract remainder unit and one remainder check; a candidate ends with one more
// compare once the square passes it (a prime c tries about sqrt(c) divisors)
// a word is taken, classified and given a result, plus a check per first prime tried
// plus its candidates; arst_n clears the sequencer and the output valid
// a new word is taken while the last result waits; a finished one holds until it drains
`include "assert_macros.svh"

module goldbach_prime_pair_search import gbps_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	gbps_in_if.sink    din,
	gbps_out_if.source dout
);

	gbps_cmd_t cmd;
	gbps_sts_t sts;

	// sequencer
	gbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	gbps_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.even_value   (din.even_value),
		.first_prime  (dout.first_prime),
		.second_prime (dout.second_prime),
		.found        (dout.found)
	);

	// busy once a word is taken
	`GBPS_ASSERT_NXT(a_busy_after_accept, din.valid && din.ready, !din.ready)
	// a miss reports both primes as zero
	`GBPS_ASSERT_IMP(a_miss_zero, dout.valid && !dout.found,
		dout.first_prime == '0 && dout.second_prime == '0)
	// the smaller prime comes first
	`GBPS_ASSERT_IMP(a_pair_order, dout.valid && dout.found,
		dout.first_prime <= dout.second_prime && dout.first_prime != '0)

endmodule
